### rtl/ppsb_pkg.sv
// shared constants, types and the arctangent table of the polar sector binner
package ppsb_pkg;

  localparam int COORD_W       = 12;
  localparam int FRAC_BITS     = 4;
  localparam int CENTER_W      = 17;
  localparam int COUNT_W       = 9;
  localparam int PIX_W         = 32;
  localparam int RADIUS_W      = 17;
  localparam int ANGLE_W       = 16;
  localparam int SECTOR_W      = 8;
  localparam int GUARD_BITS    = 8;
  localparam int CORDIC_STAGES = 16;
  localparam int TURN_W        = 32;
  localparam int MAX_SECTORS   = 256;

  // center difference: 12.4 column minus signed 12.4 center, held in 19 bits
  localparam int DIFF_W = COORD_W + FRAC_BITS + 3;
  // datapath after guard bits, with room for the cordic gain
  localparam int VEC_W  = DIFF_W + GUARD_BITS + 3;
  // final x stays below 2^27, one spare bit
  localparam int XMAG_W = 28;
  localparam int GAIN_W = 32;
  localparam int PROD_W = XMAG_W + GAIN_W;
  localparam int RSUM_W = PROD_W + 1;
  localparam int RSHIFT = GAIN_W + GUARD_BITS;
  localparam int RTOP_W = RSUM_W - RSHIFT;
  // angle offset by a full turn and scaled by the count
  localparam int AOFF_W = ANGLE_W + 1;
  localparam int SPROD_W = AOFF_W + COUNT_W - 1;
  localparam int QUO_W   = COUNT_W;

  // prep register, cordic stages, three post stages
  localparam int PIPE_LAT = CORDIC_STAGES + 4;

  localparam logic [GAIN_W-1:0]   INV_GAIN   = 32'h9B74_EDA8;
  localparam logic [RSUM_W-1:0]   RADIUS_RND = RSUM_W'(1) << (RSHIFT - 1);
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};
  localparam logic [TURN_W-1:0]   HALF_TURN  = 32'h8000_0000;
  localparam logic [TURN_W-1:0]   ANGLE_RND  = 32'h0000_8000;
  localparam logic [SPROD_W-1:0]  SECTOR_RND = SPROD_W'(32768);
  localparam logic [COUNT_W-1:0]  COUNT_RESET = COUNT_W'(8);
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = COUNT_W'(MAX_SECTORS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd2;

  typedef struct packed {
    logic              vld;
    logic              zero;
    logic [VEC_W-1:0]  x;
    logic [VEC_W-1:0]  y;
    logic [TURN_W-1:0] z;
    logic [PIX_W-1:0]  pix;
  } vec_t;

  // atan(2^-i) in 1/2^32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667336;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/ppsb_prep.sv
// center subtraction, half-turn pre-rotation and guard scaling, one register stage
module ppsb_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [ppsb_pkg::COORD_W-1:0]       column_i,
  input  logic [ppsb_pkg::COORD_W-1:0]       row_i,
  input  logic [ppsb_pkg::PIX_W-1:0]         pixel_value_i,
  input  logic [ppsb_pkg::CENTER_W-1:0]      center_x_i,
  input  logic [ppsb_pkg::CENTER_W-1:0]      center_y_i,
  output ppsb_pkg::vec_t                     vec_o
);

  localparam int PADC = ppsb_pkg::DIFF_W - ppsb_pkg::COORD_W - ppsb_pkg::FRAC_BITS;
  localparam int PADX = ppsb_pkg::DIFF_W - ppsb_pkg::CENTER_W;
  localparam int PADV = ppsb_pkg::VEC_W - ppsb_pkg::DIFF_W - ppsb_pkg::GUARD_BITS;

  logic signed [ppsb_pkg::DIFF_W-1:0] dx, dy, xr, yr;
  logic                               neg;
  ppsb_pkg::vec_t                     vec_d, vec_q;

  always_comb begin
    dx = $signed({{PADC{1'b0}}, column_i, {ppsb_pkg::FRAC_BITS{1'b0}}})
       - $signed({{PADX{center_x_i[ppsb_pkg::CENTER_W-1]}}, center_x_i});
    dy = $signed({{PADC{1'b0}}, row_i, {ppsb_pkg::FRAC_BITS{1'b0}}})
       - $signed({{PADX{center_y_i[ppsb_pkg::CENTER_W-1]}}, center_y_i});
    neg = dx[ppsb_pkg::DIFF_W-1];
    // left half plane: rotate by half a turn first
    xr = neg ? -dx : dx;
    yr = neg ? -dy : dy;
    vec_d.vld  = valid_i;
    vec_d.zero = (dx == '0) && (dy == '0);
    vec_d.x    = {{PADV{xr[ppsb_pkg::DIFF_W-1]}}, xr, {ppsb_pkg::GUARD_BITS{1'b0}}};
    vec_d.y    = {{PADV{yr[ppsb_pkg::DIFF_W-1]}}, yr, {ppsb_pkg::GUARD_BITS{1'b0}}};
    vec_d.z    = neg ? ppsb_pkg::HALF_TURN : '0;
    vec_d.pix  = pixel_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q.vld <= 1'b0;
    end else begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

### rtl/ppsb_cordic.sv
// vectoring cordic, one registered micro-rotation per stage
module ppsb_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppsb_pkg::vec_t vec_i,
  output ppsb_pkg::vec_t vec_o
);

  ppsb_pkg::vec_t stg [ppsb_pkg::CORDIC_STAGES+1];

  assign stg[0] = vec_i;

  for (genvar i = 0; i < ppsb_pkg::CORDIC_STAGES; i++) begin : g_stage
    logic signed [ppsb_pkg::VEC_W-1:0] xc, yc, xs, ys;
    ppsb_pkg::vec_t                    nxt_d;

    always_comb begin
      xc    = stg[i].x;
      yc    = stg[i].y;
      xs    = xc >>> i;
      ys    = yc >>> i;
      nxt_d = stg[i];
      // rotate toward the x axis, y of zero counts as positive
      if (!yc[ppsb_pkg::VEC_W-1]) begin
        nxt_d.x = xc + ys;
        nxt_d.y = yc - xs;
        nxt_d.z = stg[i].z + ppsb_pkg::atan_turn(5'(i));
      end else begin
        nxt_d.x = xc - ys;
        nxt_d.y = yc + xs;
        nxt_d.z = stg[i].z - ppsb_pkg::atan_turn(5'(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg[i+1].vld <= 1'b0;
      end else begin
        stg[i+1] <= nxt_d;
      end
    end
  end

  assign vec_o = stg[ppsb_pkg::CORDIC_STAGES];

endmodule

### rtl/ppsb_post.sv
// gain correction, angle rounding and sector assignment over three register stages
module ppsb_post (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppsb_pkg::vec_t                 vec_i,
  input  logic [ppsb_pkg::COUNT_W-1:0]   sector_count_i,
  output logic                           valid_o,
  output logic [ppsb_pkg::PIX_W-1:0]     pixel_out_o,
  output logic [ppsb_pkg::RADIUS_W-1:0]  radius_o,
  output logic [ppsb_pkg::ANGLE_W-1:0]   angle_o,
  output logic [ppsb_pkg::SECTOR_W-1:0]  sector_o
);

  // stage a: gain multiply and angle rounding
  logic                           a_vld_q;
  logic [ppsb_pkg::PROD_W-1:0]    a_prod_d, a_prod_q;
  logic [ppsb_pkg::TURN_W-1:0]    a_zr;
  logic [ppsb_pkg::ANGLE_W-1:0]   a_ang_d, a_ang_q;
  logic [ppsb_pkg::PIX_W-1:0]     a_pix_q;

  always_comb begin
    a_prod_d = ppsb_pkg::PROD_W'(vec_i.x[ppsb_pkg::XMAG_W-1:0])
             * ppsb_pkg::PROD_W'(ppsb_pkg::INV_GAIN);
    a_zr     = vec_i.z + ppsb_pkg::ANGLE_RND;
    a_ang_d  = vec_i.zero ? '0 : a_zr[ppsb_pkg::TURN_W-1 -: ppsb_pkg::ANGLE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q  <= vec_i.vld;
      a_prod_q <= a_prod_d;
      a_ang_q  <= a_ang_d;
      a_pix_q  <= vec_i.pix;
    end
  end

  // stage b: radius rounding and saturation, angle times count
  logic                            b_vld_q;
  logic [ppsb_pkg::RSUM_W-1:0]     b_rsum;
  logic [ppsb_pkg::RTOP_W-1:0]     b_rtop;
  logic [ppsb_pkg::RADIUS_W-1:0]   b_rad_d, b_rad_q;
  logic [ppsb_pkg::COUNT_W-1:0]    b_cnt_d, b_cnt_q;
  logic [ppsb_pkg::AOFF_W-1:0]     b_aoff;
  logic [ppsb_pkg::SPROD_W-1:0]    b_sprod;
  logic [ppsb_pkg::QUO_W-1:0]      b_quo_d, b_quo_q;
  logic [ppsb_pkg::ANGLE_W-1:0]    b_ang_q;
  logic [ppsb_pkg::PIX_W-1:0]      b_pix_q;

  always_comb begin
    b_rsum  = {1'b0, a_prod_q} + ppsb_pkg::RADIUS_RND;
    b_rtop  = b_rsum[ppsb_pkg::RSUM_W-1:ppsb_pkg::RSHIFT];
    b_rad_d = (b_rtop > ppsb_pkg::RTOP_W'(ppsb_pkg::RADIUS_MAX))
            ? ppsb_pkg::RADIUS_MAX : b_rtop[ppsb_pkg::RADIUS_W-1:0];
    if (sector_count_i == '0) begin
      b_cnt_d = ppsb_pkg::COUNT_W'(1);
    end else if (sector_count_i > ppsb_pkg::COUNT_MAX) begin
      b_cnt_d = ppsb_pkg::COUNT_MAX;
    end else begin
      b_cnt_d = sector_count_i;
    end
    // signed angle plus a full turn
    b_aoff  = {~a_ang_q[ppsb_pkg::ANGLE_W-1], a_ang_q};
    b_sprod = ppsb_pkg::SPROD_W'(b_aoff) * ppsb_pkg::SPROD_W'(b_cnt_d)
            + ppsb_pkg::SECTOR_RND;
    b_quo_d = b_sprod[ppsb_pkg::SPROD_W-1 -: ppsb_pkg::QUO_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
      b_rad_q <= b_rad_d;
      b_cnt_q <= b_cnt_d;
      b_quo_q <= b_quo_d;
      b_ang_q <= a_ang_q;
      b_pix_q <= a_pix_q;
    end
  end

  // stage c: quotient lies below twice the count, one conditional subtract
  logic [ppsb_pkg::QUO_W-1:0]     c_mod;
  logic                           c_vld_q;
  logic [ppsb_pkg::SECTOR_W-1:0]  c_sec_q;
  logic [ppsb_pkg::RADIUS_W-1:0]  c_rad_q;
  logic [ppsb_pkg::ANGLE_W-1:0]   c_ang_q;
  logic [ppsb_pkg::PIX_W-1:0]     c_pix_q;

  always_comb begin
    c_mod = (b_quo_q >= b_cnt_q) ? (b_quo_q - b_cnt_q) : b_quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
      c_sec_q <= c_mod[ppsb_pkg::SECTOR_W-1:0];
      c_rad_q <= b_rad_q;
      c_ang_q <= b_ang_q;
      c_pix_q <= b_pix_q;
    end
  end

  assign valid_o     = c_vld_q;
  assign pixel_out_o = c_pix_q;
  assign radius_o    = c_rad_q;
  assign angle_o     = c_ang_q;
  assign sector_o    = c_sec_q;

endmodule

### rtl/pixel_polar_sector_binner.sv
// top level of the polar sector binner: config registers and the pipeline
// Takes one pixel per clock (busy never rises) and returns its radius, angle
// and sector once the start transfer has passed the center subtraction
// register, the registered cordic stages, and the stages for the gain
// multiply, rounding and sector modulo. Results appear on result_valid_o
// for one cycle each, in input order, and must be taken then.
// Configuration writes take effect on the next cycle; the user makes them
// only while no pixel is in flight, which the block itself does not enforce.
module pixel_polar_sector_binner (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ppsb_pkg::COORD_W-1:0]       column_i,
  input  logic [ppsb_pkg::COORD_W-1:0]       row_i,
  input  logic [ppsb_pkg::PIX_W-1:0]         pixel_value_i,
  input  logic                               cfg_we_i,
  input  logic [ppsb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppsb_pkg::CENTER_W-1:0]      cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [ppsb_pkg::PIX_W-1:0]         pixel_out_o,
  output logic [ppsb_pkg::RADIUS_W-1:0]      radius_o,
  output logic [ppsb_pkg::ANGLE_W-1:0]       angle_o,
  output logic [ppsb_pkg::SECTOR_W-1:0]      sector_o
);

  logic [ppsb_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic [ppsb_pkg::COUNT_W-1:0]  sector_count_q;
  ppsb_pkg::vec_t                prep_vec, cordic_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      sector_count_q <= ppsb_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppsb_pkg::REG_CENTER_X:     center_x_q     <= cfg_wdata_i;
        ppsb_pkg::REG_CENTER_Y:     center_y_q     <= cfg_wdata_i;
        ppsb_pkg::REG_SECTOR_COUNT: sector_count_q <= cfg_wdata_i[ppsb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ppsb_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start & ~busy),
    .column_i      (column_i),
    .row_i         (row_i),
    .pixel_value_i (pixel_value_i),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .vec_o         (prep_vec)
  );

  ppsb_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (prep_vec),
    .vec_o  (cordic_vec)
  );

  ppsb_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vec_i          (cordic_vec),
    .sector_count_i (sector_count_q),
    .valid_o        (result_valid_o),
    .pixel_out_o    (pixel_out_o),
    .radius_o       (radius_o),
    .angle_o        (angle_o),
    .sector_o       (sector_o)
  );

endmodule

### rtl/ppsb_checker.sv
// port-level checks of the polar sector binner, bound to the top level
module ppsb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [ppsb_pkg::PIX_W-1:0]         pixel_value_i,
  input logic                               cfg_we_i,
  input logic [ppsb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [ppsb_pkg::CENTER_W-1:0]      cfg_wdata_i,
  input logic                               result_valid_o,
  input logic [ppsb_pkg::PIX_W-1:0]         pixel_out_o,
  input logic [ppsb_pkg::RADIUS_W-1:0]      radius_o,
  input logic [ppsb_pkg::ANGLE_W-1:0]       angle_o,
  input logic [ppsb_pkg::SECTOR_W-1:0]      sector_o
);

  localparam int WARM_W = $clog2(ppsb_pkg::PIPE_LAT + 1);

  logic [WARM_W-1:0]            warm_q;
  logic                         warm;
  logic [ppsb_pkg::COUNT_W-1:0] cnt_q, eff_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
      cnt_q  <= ppsb_pkg::COUNT_RESET;
    end else begin
      if (warm_q != WARM_W'(ppsb_pkg::PIPE_LAT)) begin
        warm_q <= warm_q + 1'b1;
      end
      if (cfg_we_i && (cfg_idx_i == ppsb_pkg::REG_SECTOR_COUNT)) begin
        cnt_q <= cfg_wdata_i[ppsb_pkg::COUNT_W-1:0];
      end
    end
  end

  assign warm = (warm_q == WARM_W'(ppsb_pkg::PIPE_LAT));

  always_comb begin
    if (cnt_q == '0) begin
      eff_cnt = ppsb_pkg::COUNT_W'(1);
    end else if (cnt_q > ppsb_pkg::COUNT_MAX) begin
      eff_cnt = ppsb_pkg::COUNT_MAX;
    end else begin
      eff_cnt = cnt_q;
    end
  end

  // every transfer in gives exactly one result at the pipeline output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (result_valid_o == $past(start && !busy, ppsb_pkg::PIPE_LAT)))
    else $error("result strobe does not follow start transfer");

  a_pixel_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && result_valid_o) |->
      (pixel_out_o == $past(pixel_value_i, ppsb_pkg::PIPE_LAT)))
    else $error("pixel word altered or out of order");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ({1'b0, sector_o} < eff_cnt))
    else $error("sector beyond configured count");

  // zero angle always lands in sector zero
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (angle_o == '0)) |-> (sector_o == '0))
    else $error("zero angle not in sector zero");

  // a zero radius can only come from the zero vector
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (radius_o == '0)) |-> (angle_o == '0))
    else $error("zero radius with nonzero angle");

endmodule

bind pixel_polar_sector_binner ppsb_checker u_ppsb_checker (.*);
